// File: hdl/ugti_pkg.sv
// shared types and constants of the uniform grid table interpolator
`default_nettype none
package ugti_pkg;

  localparam int SECTION_COUNT_DEF = 32;
  localparam int GRID_POINTS_DEF   = 512;

  localparam int VALUE_W   = 32;
  localparam int ENERGY_W  = 24;
  localparam int SEC_W     = 6;
  localparam int POINT_W   = 12;
  localparam int FRAC_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * ENERGY_W;
  localparam int IDX_W     = PROD_W - 16;
  localparam int IP_W      = IDX_W - FRAC_W;

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_INTERP = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_SECTION = 2'd1,
    ST_BAD_INDEX   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_SINGLE,
    OP_BLEND
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ENERGY = 2'd0,
    CFG_MAX_ENERGY = 2'd1,
    CFG_INV_STEP   = 2'd2
  } cfg_reg_t;

  // request as it reaches the table banks
  typedef struct packed {
    logic                 valid;
    op_t                  op;
    status_t              status;
    logic [SEC_W-1:0]     sec;
    logic [POINT_W-1:0]   pt;
    logic [VALUE_W-1:0]   wval;
    logic [FRAC_W-1:0]    frac;
  } req_t;

  // control that travels beside the bank read data
  typedef struct packed {
    logic                 valid;
    logic                 zero;
    status_t              status;
    logic                 a_odd;
    logic [FRAC_W-1:0]    frac;
  } blend_ctl_t;

endpackage
`default_nettype wire

// File: hdl/ugti_front.sv
// request decode, range checks and grid index multiply
`default_nettype none
module ugti_front #(
  parameter int SECTION_COUNT = 32,
  parameter int GRID_POINTS   = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_take,
  input  logic [1:0]                    in_mode,
  input  logic [ugti_pkg::SEC_W-1:0]    in_section,
  input  logic [ugti_pkg::POINT_W-1:0]  in_energy_index,
  input  logic [ugti_pkg::ENERGY_W-1:0] in_energy,
  input  logic [ugti_pkg::VALUE_W-1:0]  in_entry_value,
  input  logic [ugti_pkg::ENERGY_W-1:0] min_energy,
  input  logic [ugti_pkg::ENERGY_W-1:0] max_energy,
  input  logic [ugti_pkg::ENERGY_W-1:0] inv_step,
  output ugti_pkg::req_t                req
);
  import ugti_pkg::*;

  mode_t                mode_s0;
  op_t                  op_s0;
  status_t              st_s0;
  logic [POINT_W-1:0]   pt_s0;
  logic                 sec_bad;
  logic                 pt_bad;

  logic                 s1_valid_r;
  op_t                  s1_op_r;
  status_t              s1_status_r;
  logic [SEC_W-1:0]     s1_sec_r;
  logic [POINT_W-1:0]   s1_pt_r;
  logic [VALUE_W-1:0]   s1_wval_r;
  logic [ENERGY_W-1:0]  s1_diff_r;
  logic [PROD_W-1:0]    prod_s1;

  logic                 s2_valid_r;
  op_t                  s2_op_r;
  status_t              s2_status_r;
  logic [SEC_W-1:0]     s2_sec_r;
  logic [POINT_W-1:0]   s2_pt_r;
  logic [VALUE_W-1:0]   s2_wval_r;
  logic [IDX_W-1:0]     s2_idx_r;
  logic [IP_W-1:0]      ip_s2;
  logic                 ip_bad;

  assign mode_s0 = mode_t'(in_mode);
  assign sec_bad = 32'(in_section) >= 32'(SECTION_COUNT);
  assign pt_bad  = 32'(in_energy_index) >= 32'(GRID_POINTS);

  always_comb begin
    op_s0 = OP_NONE;
    st_s0 = ST_OK;
    pt_s0 = in_energy_index;
    priority if (mode_s0 == MODE_NONE) begin
      op_s0 = OP_NONE;
    end else if (sec_bad) begin
      st_s0 = ST_BAD_SECTION;
    end else if (mode_s0 == MODE_WRITE || mode_s0 == MODE_READ) begin
      if (pt_bad) begin
        st_s0 = ST_BAD_INDEX;
      end else if (mode_s0 == MODE_WRITE) begin
        op_s0 = OP_WRITE;
      end else begin
        op_s0 = OP_SINGLE;
      end
    end else if (in_energy <= min_energy) begin
      op_s0 = OP_SINGLE;
      pt_s0 = '0;
    end else if (in_energy >= max_energy) begin
      op_s0 = OP_SINGLE;
      pt_s0 = POINT_W'(GRID_POINTS - 1);
    end else begin
      op_s0 = OP_BLEND;
    end
  end

  // stage 1: checks done, energy offset from grid start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r     <= op_s0;
    s1_status_r <= st_s0;
    s1_sec_r    <= in_section;
    s1_pt_r     <= pt_s0;
    s1_wval_r   <= in_entry_value;
    s1_diff_r   <= in_energy - min_energy;
  end

  assign prod_s1 = PROD_W'(s1_diff_r) * PROD_W'(inv_step);

  // stage 2: scaled grid index in q.12
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r     <= s1_op_r;
    s2_status_r <= s1_status_r;
    s2_sec_r    <= s1_sec_r;
    s2_pt_r     <= s1_pt_r;
    s2_wval_r   <= s1_wval_r;
    s2_idx_r    <= prod_s1[PROD_W-1:16];
  end

  assign ip_s2  = s2_idx_r[IDX_W-1:FRAC_W];
  assign ip_bad = 32'(ip_s2) > 32'(GRID_POINTS - 2);

  always_comb begin
    req.valid  = s2_valid_r;
    req.op     = s2_op_r;
    req.status = s2_status_r;
    req.sec    = s2_sec_r;
    req.pt     = s2_pt_r;
    req.wval   = s2_wval_r;
    req.frac   = '0;
    if (s2_op_r == OP_BLEND) begin
      if (ip_bad) begin
        req.op     = OP_NONE;
        req.status = ST_BAD_INDEX;
      end else begin
        req.pt   = ip_s2[POINT_W-1:0];
        req.frac = s2_idx_r[FRAC_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/ugti_bank.sv
// one table bank, single write port, registered read
`default_nettype none
module ugti_bank #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                addr,
  input  logic [ugti_pkg::VALUE_W-1:0] wdata,
  output logic [ugti_pkg::VALUE_W-1:0] rdata
);
  import ugti_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: hdl/ugti_blend.sv
// linear blend between two neighboring entries
`default_nettype none
module ugti_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ugti_pkg::blend_ctl_t         ctl,
  input  logic [ugti_pkg::VALUE_W-1:0] rd_even,
  input  logic [ugti_pkg::VALUE_W-1:0] rd_odd,
  output logic                         out_strobe,
  output logic [ugti_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                   out_status
);
  import ugti_pkg::*;

  localparam int MUL_W = VALUE_W + FRAC_W;

  blend_ctl_t           s3_ctl_r;
  logic [VALUE_W-1:0]   a_s3;
  logic [VALUE_W-1:0]   b_s3;
  logic                 down_s3;
  logic [VALUE_W-1:0]   mag_s3;

  logic                 s4_valid_r;
  logic                 s4_zero_r;
  status_t              s4_status_r;
  logic [VALUE_W-1:0]   s4_a_r;
  logic [MUL_W-1:0]     s4_prod_r;
  logic                 s4_down_r;
  logic [MUL_W:0]       ceil_s4;
  logic [VALUE_W-1:0]   val_s4;

  logic                 out_strobe_r;
  logic [VALUE_W-1:0]   out_value_r;
  status_t              out_status_r;

  // control lines up with the registered bank data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r.valid <= 1'b0;
    end else begin
      s3_ctl_r.valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_ctl_r.zero   <= ctl.zero;
    s3_ctl_r.status <= ctl.status;
    s3_ctl_r.a_odd  <= ctl.a_odd;
    s3_ctl_r.frac   <= ctl.frac;
  end

  // a zero fraction takes no neighbor, so the other bank is ignored
  assign a_s3    = s3_ctl_r.a_odd ? rd_odd : rd_even;
  assign b_s3    = (s3_ctl_r.frac == '0) ? a_s3 : (s3_ctl_r.a_odd ? rd_even : rd_odd);
  assign down_s3 = b_s3 < a_s3;
  assign mag_s3  = down_s3 ? (a_s3 - b_s3) : (b_s3 - a_s3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_zero_r   <= s3_ctl_r.zero;
    s4_status_r <= s3_ctl_r.status;
    s4_a_r      <= a_s3;
    s4_prod_r   <= MUL_W'(mag_s3) * MUL_W'(s3_ctl_r.frac);
    s4_down_r   <= down_s3;
  end

  // falling slope rounds the step up so the result floors
  assign ceil_s4 = (MUL_W + 1)'(s4_prod_r) + (MUL_W + 1)'((1 << FRAC_W) - 1);

  always_comb begin
    if (s4_zero_r) begin
      val_s4 = '0;
    end else if (s4_down_r) begin
      val_s4 = s4_a_r - ceil_s4[FRAC_W +: VALUE_W];
    end else begin
      val_s4 = s4_a_r + s4_prod_r[FRAC_W +: VALUE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= val_s4;
    out_status_r <= s4_status_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

// File: hdl/uniform_grid_table_interpolator_unit.sv
// top level of the uniform grid table interpolator
//
// command channel: a beat is taken at each clock edge with start high and
// busy low. busy never rises, so a new command can be issued every cycle.
// mode 0 writes entry_value at (section, energy_index), mode 2 reads that
// entry back, mode 1 interpolates the section's table at a q12.12 energy.
// every command gives exactly one result beat: out_strobe is high for one
// cycle, with out_value (q16.16) and out_status, once the command has passed
// the stage 1, stage 2, bank read, stage 4 and output registers. results
// leave in command order; the receiver cannot stall.
// throughput is one command per cycle. the table is split into an even and
// an odd point bank so both neighbors of a blend are read together; each
// bank has one port, used by the single memory stage of the pipe, so a
// write is seen by every command behind it without forwarding.
// config beats (cfg_valid, cfg_ready always high) set grid min, grid max and
// inverse step; the user sees that they are written only while no command is
// in flight, unchecked by the block. reset clears the pipe and loads the
// register defaults; tables are undefined until written (no clearing pass).
`default_nettype none
module uniform_grid_table_interpolator_unit #(
  parameter int SECTION_COUNT = ugti_pkg::SECTION_COUNT_DEF,
  parameter int GRID_POINTS   = ugti_pkg::GRID_POINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_mode,
  input  logic [ugti_pkg::SEC_W-1:0]     in_section,
  input  logic [ugti_pkg::POINT_W-1:0]   in_energy_index,
  input  logic [ugti_pkg::ENERGY_W-1:0]  in_energy,
  input  logic [ugti_pkg::VALUE_W-1:0]   in_entry_value,
  output logic                           out_strobe,
  output logic [ugti_pkg::VALUE_W-1:0]   out_value,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ugti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ugti_pkg::ENERGY_W-1:0]  cfg_data
);
  import ugti_pkg::*;

  // points per section in each bank, odd point counts round up
  localparam int HALF       = (GRID_POINTS + 1) / 2;
  localparam int BANK_DEPTH = SECTION_COUNT * HALF;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [ENERGY_W-1:0] min_energy_r;
  logic [ENERGY_W-1:0] max_energy_r;
  logic [ENERGY_W-1:0] inv_step_r;
  logic                cfg_take;
  logic                in_take;

  req_t                req;
  logic                pair_odd;
  logic [POINT_W-1:0]  even_half;
  logic [POINT_W-1:0]  odd_half;
  logic [BANK_AW-1:0]  even_addr;
  logic [BANK_AW-1:0]  odd_addr;
  logic                table_wr;
  logic                even_we;
  logic                odd_we;
  logic [VALUE_W-1:0]  rd_even;
  logic [VALUE_W-1:0]  rd_odd;
  blend_ctl_t          ctl;

  // no stall source inside the pipe
  assign busy      = 1'b0;
  assign in_take   = start & ~busy;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;

  // grid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_energy_r <= '0;
      max_energy_r <= '1;
      inv_step_r   <= ENERGY_W'(65536);
    end else if (cfg_take) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MIN_ENERGY: min_energy_r <= cfg_data;
        CFG_MAX_ENERGY: max_energy_r <= cfg_data;
        CFG_INV_STEP:   inv_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode, range checks, grid index
  ugti_front #(
    .SECTION_COUNT (SECTION_COUNT),
    .GRID_POINTS   (GRID_POINTS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_take         (in_take),
    .in_mode         (in_mode),
    .in_section      (in_section),
    .in_energy_index (in_energy_index),
    .in_energy       (in_energy),
    .in_entry_value  (in_entry_value),
    .min_energy      (min_energy_r),
    .max_energy      (max_energy_r),
    .inv_step        (inv_step_r),
    .req             (req)
  );

  // a blend from an odd point takes its upper neighbor from the next even row
  assign pair_odd  = (req.op == OP_BLEND) && req.pt[0];
  assign even_half = (req.pt + POINT_W'(pair_odd)) >> 1;
  assign odd_half  = req.pt >> 1;
  assign even_addr = BANK_AW'(32'(req.sec) * HALF + 32'(even_half));
  assign odd_addr  = BANK_AW'(32'(req.sec) * HALF + 32'(odd_half));

  assign table_wr = req.valid && (req.op == OP_WRITE);
  assign even_we  = table_wr && !req.pt[0];
  assign odd_we   = table_wr && req.pt[0];

  ugti_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_bank_even (
    .clk   (clk),
    .we    (even_we),
    .addr  (even_addr),
    .wdata (req.wval),
    .rdata (rd_even)
  );

  ugti_bank #(
    .DEPTH (BANK_DEPTH),
    .AW    (BANK_AW)
  ) u_bank_odd (
    .clk   (clk),
    .we    (odd_we),
    .addr  (odd_addr),
    .wdata (req.wval),
    .rdata (rd_odd)
  );

  // writes, errors and the unused mode answer zero
  always_comb begin
    ctl.valid  = req.valid;
    ctl.zero   = (req.op == OP_NONE) || (req.op == OP_WRITE);
    ctl.status = req.status;
    ctl.a_odd  = req.pt[0];
    ctl.frac   = req.frac;
  end

  ugti_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_even    (rd_even),
    .rd_odd     (rd_odd),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
`default_nettype wire
